[rtl/clm_pkg.sv]
// Shared types and codes for the circular list manager.
package clm_pkg;

	localparam int VAL_W = 32;

	// Command codes carried on the input tuser
	typedef enum logic [1:0] {
		CMD_PUSH_HEAD = 2'd0,
		CMD_PUSH_TAIL = 2'd1,
		CMD_DELETE    = 2'd2,
		CMD_CLEAR     = 2'd3
	} cmd_t;

	// Status codes carried on the output tuser
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SWEEP
	} fsm_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic             push_head;
		logic             push_tail;
		logic             clear;
		logic             start;
		logic [VAL_W-1:0] ins_value;
		logic [VAL_W-1:0] key;
	} clm_ctl_t;

	// Handed from a cell to its right neighbor (toward the tail)
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] value;
		logic             srch;
		logic             shft;
	} clm_right_t;

	// Handed from a cell to its left neighbor (toward the head)
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] value;
		logic             shft;
	} clm_left_t;

	// Sweep completion flags
	typedef struct packed {
		logic ok;
		logic miss;
	} clm_done_t;

endpackage

[rtl/clm_cell.sv]
// One list node cell: holds a value, its valid bit and the sweep tokens.
module clm_cell
	import clm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  clm_ctl_t   ctl,
	input  clm_right_t from_left,
	input  clm_left_t  from_right,
	output clm_right_t to_right,
	output clm_left_t  to_left,
	output clm_done_t  done
);

	logic             valid_q;
	logic [VAL_W-1:0] value_q;
	logic             srch_q;
	logic             shft_q;
	logic             hit;
	logic             pass_srch;
	logic             pass_shft;

	// Search token sits here and the node matches the key
	assign hit = srch_q && valid_q && (value_q == ctl.key);

	// Token hand-off; the right neighbor being empty marks the end of the list
	always_comb begin
		pass_srch = srch_q && valid_q && !hit && from_right.valid;
		pass_shft = (hit || shft_q) && from_right.valid;
		done.miss = srch_q && (!valid_q || (!hit && !from_right.valid));
		done.ok   = (hit || shft_q) && !from_right.valid;
	end

	assign to_right = '{valid: valid_q, value: value_q, srch: pass_srch, shft: pass_shft};
	assign to_left  = '{valid: valid_q, value: value_q, shft: shft_q};

	// Valid bit and tokens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			srch_q  <= 1'b0;
			shft_q  <= 1'b0;
		end else begin
			srch_q <= from_left.srch;
			shft_q <= from_left.shft;
			if (ctl.clear) begin
				valid_q <= 1'b0;
			end else if (ctl.push_head) begin
				valid_q <= from_left.valid;
			end else if (ctl.push_tail) begin
				valid_q <= valid_q | from_left.valid;
			end else if (from_right.shft) begin
				valid_q <= from_right.valid;
			end else if (hit || shft_q) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Node value: shift right on head insert, fill first empty cell on tail insert,
	// pull from the right while a deletion closes the gap
	always_ff @(posedge clk) begin
		if (ctl.push_head) begin
			value_q <= from_left.value;
		end else if (ctl.push_tail && from_left.valid && !valid_q) begin
			value_q <= ctl.ins_value;
		end else if (from_right.shft) begin
			value_q <= from_right.value;
		end
	end

endmodule

[rtl/clm_chain.sv]
// Row of node cells, head at cell 0, with the sweep completion reduction.
module clm_chain
	import clm_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  clm_ctl_t  ctl,
	output clm_done_t done
);

	clm_right_t            to_right [CAPACITY];
	clm_left_t             to_left  [CAPACITY];
	logic [CAPACITY-1:0]   ok_vec;
	logic [CAPACITY-1:0]   miss_vec;
	clm_right_t            head_in;
	clm_left_t             tail_in;

	// Left of the head: the word to insert and the search start
	always_comb begin
		head_in.valid = 1'b1;
		head_in.value = ctl.ins_value;
		head_in.srch  = ctl.start;
		head_in.shft  = 1'b0;
	end

	// Right of the last cell: always empty
	always_comb begin
		tail_in.valid = 1'b0;
		tail_in.value = '0;
		tail_in.shft  = 1'b0;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		clm_right_t lin;
		clm_left_t  rin;
		clm_done_t  cdone;

		if (i == 0) begin : g_first
			assign lin = head_in;
		end else begin : g_mid_l
			assign lin = to_right[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rin = tail_in;
		end else begin : g_mid_r
			assign rin = to_left[i+1];
		end

		clm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.from_left  (lin),
			.from_right (rin),
			.to_right   (to_right[i]),
			.to_left    (to_left[i]),
			.done       (cdone)
		);

		assign ok_vec[i]   = cdone.ok;
		assign miss_vec[i] = cdone.miss;
	end

	// At most one cell holds a token, so a plain OR merges the flags
	assign done = '{ok: |ok_vec, miss: |miss_vec};

endmodule

[rtl/circular_list_manager.sv]
// Top level of the circular list manager: command control and result register.
//
//  channel | dir | tdata            | tuser        | notes
//  --------+-----+------------------+--------------+----------------------------
//  s_*     | in  | value (32, sgn)  | command (2)  | one command word per accept
//  m_*     | out | node_count       | status (2)   | one result word per command
//
// Insert, clear and delete on an empty list take effect at the accepting edge; the
// result is valid the next cycle. Delete walks a token one cell per clock from the head
// and, on a match, closes the gap one cell per clock toward the tail, so the result is
// registered when the token reaches the end of the list either way, and the command
// holds the input until then. One command is in flight at a time; a waiting result
// holds off the next command only until it is taken in the same cycle. Reset empties
// the list at once, no clearing pass.
module circular_list_manager
	import clm_pkg::*;
#(
	parameter int CAPACITY = 64,
	localparam int CNT_W   = $clog2(CAPACITY + 1),
	localparam int OUT_W   = ((CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VAL_W-1:0] s_tdata,   // [31:0] value
	input  logic [1:0]       s_tuser,   // [1:0] command
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // [CNT_W-1:0] node_count, zero fill above
	output logic [1:0]       m_tuser    // [1:0] status
);

	fsm_t             state_q;
	fsm_t             state_d;
	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] key_q;
	status_t          status_q;
	logic             m_tvalid_q;
	logic             accept;
	logic             full;
	logic             empty;
	logic             sweep_done;
	cmd_t             cmd;
	clm_ctl_t         ctl;
	clm_done_t        done;
	status_t          imm_status;
	logic [CNT_W-1:0] imm_count;

	assign cmd    = cmd_t'(s_tuser);
	assign accept = s_tvalid && s_tready;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);
	assign sweep_done = (state_q == FSM_SWEEP) && (done.ok || done.miss);

	// Broadcast to the cells
	always_comb begin
		ctl.push_head = accept && (cmd == CMD_PUSH_HEAD) && !full;
		ctl.push_tail = accept && (cmd == CMD_PUSH_TAIL) && !full;
		ctl.clear     = accept && (cmd == CMD_CLEAR);
		ctl.start     = accept && (cmd == CMD_DELETE) && !empty;
		ctl.ins_value = s_tdata;
		ctl.key       = key_q;
	end

	clm_chain #(
		.CAPACITY (CAPACITY)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.done   (done)
	);

	// Result of commands that finish at acceptance
	always_comb begin
		imm_status = STAT_OK;
		imm_count  = count_q;
		case (cmd)
			CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
				if (full) begin
					imm_status = STAT_FULL;
				end else begin
					imm_count = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				imm_status = STAT_EMPTY;
			end
			CMD_CLEAR: begin
				imm_count = '0;
			end
			default: begin
				imm_status = STAT_OK;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (ctl.start) begin
					state_d = FSM_SWEEP;
				end
			end
			FSM_SWEEP: begin
				if (done.ok || done.miss) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		s_tready = (state_q == FSM_IDLE) && (!m_tvalid_q || m_tready);
		m_tvalid = m_tvalid_q;
		m_tuser  = status_q;
		m_tdata  = OUT_W'(count_q);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && !ctl.start) begin
				m_tvalid_q <= 1'b1;
				count_q    <= imm_count;
			end else if (sweep_done) begin
				m_tvalid_q <= 1'b1;
				if (done.ok) begin
					count_q <= count_q - CNT_W'(1);
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Result status and search key
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= s_tdata;
		end
		if (accept && !ctl.start) begin
			status_q <= imm_status;
		end else if (sweep_done) begin
			status_q <= done.ok ? STAT_OK : STAT_NOT_FOUND;
		end
	end

endmodule
